FILE: design/bitmap_block_allocator_core_macros.svh
// Assertion macros for the bitmap block allocator.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg)
`endif
`endif

FILE: design/bba_pkg.sv
// Shared types and codes for the bitmap block allocator.
// Used by bba_step and bitmap_block_allocator_core; depends on nothing.
package bba_pkg;

    localparam int unsigned MapW  = 64;
    localparam int unsigned AddrW = 64;
    localparam int unsigned IdxW  = 6;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADADDR = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [AddrW-1:0]  address;
    } t_req;

    // packed so that status lands in the low bits
    typedef struct packed {
        logic [MapW-1:0]   map;
        logic [AddrW-1:0]  address;
        logic [IdxW-1:0]   index;
        t_status           status;
    } t_rsp;

endpackage

FILE: design/bba_step.sv
// Combinational request evaluation: lowest-free search, address check, map update.
// Depends on bba_pkg.
module bba_step #(
    parameter int unsigned NUM_BLOCKS  = 64,
    parameter int unsigned BLOCK_SHIFT = 21
) (
    input  bba_pkg::t_req               i_req,
    input  logic [bba_pkg::AddrW-1:0]   i_base,
    input  logic [bba_pkg::MapW-1:0]    i_map,
    output bba_pkg::t_rsp               o_rsp
);
    import bba_pkg::*;

    localparam logic [MapW-1:0]  PoolMask = (NUM_BLOCKS >= 64) ? {MapW{1'b1}} :
                                            ((64'd1 << NUM_BLOCKS) - 64'd1);
    localparam logic [AddrW-1:0] LowMask  = (64'd1 << BLOCK_SHIFT) - 64'd1;
    localparam logic [AddrW-1:0] NumBlk   = 64'(NUM_BLOCKS);

    logic [MapW-1:0]   w_avail;
    logic [MapW-1:0]   w_onehot;
    logic [IdxW-1:0]   w_idx;
    logic              w_have;
    logic [AddrW:0]    w_diff;
    logic [AddrW-1:0]  w_off;
    logic [AddrW-1:0]  w_blk;
    logic              w_bad;

    assign w_avail  = (i_base != '0) ? (i_map & PoolMask) : '0;
    assign w_onehot = w_avail & (~w_avail + 64'd1);
    assign w_have   = (w_avail != '0);

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (w_onehot[i]) begin
                w_idx = w_idx | IdxW'(i);
            end
        end
    end

    assign w_diff = {1'b0, i_req.address} - {1'b0, i_base};
    assign w_off  = w_diff[AddrW-1:0];
    assign w_blk  = w_off >> BLOCK_SHIFT;
    assign w_bad  = (i_req.address == '0) || (i_base == '0) || w_diff[AddrW] ||
                    (w_blk >= NumBlk) || ((w_off & LowMask) != '0);

    always_comb begin
        o_rsp.status  = ST_OK;
        o_rsp.index   = '0;
        o_rsp.address = '0;
        o_rsp.map     = i_map;
        case (i_req.func)
            FUNC_ALLOC: begin
                if (w_have) begin
                    o_rsp.index   = w_idx;
                    o_rsp.address = i_base + ({{(AddrW-IdxW){1'b0}}, w_idx} << BLOCK_SHIFT);
                    o_rsp.map     = i_map & ~w_onehot;
                end else begin
                    o_rsp.status = ST_NOMEM;
                end
            end
            FUNC_FREE: begin
                if (w_bad) begin
                    o_rsp.status = ST_BADADDR;
                end else begin
                    o_rsp.map = i_map | (64'd1 << w_blk[IdxW-1:0]);
                end
            end
            default: begin
                o_rsp.status = ST_BADADDR;
            end
        endcase
    end

endmodule

FILE: design/bitmap_block_allocator_core.sv
// Bitmap block allocator: hands out and takes back equal power-of-two pool blocks.
// Request channel s_axis: tuser = kind (0 allocate, 1 free), tdata = address to free.
// Response channel m_axis: tdata = status, block index, block address, free map.
// Config: i_cfg_wr_en / i_cfg_wr_data load the pool base address (zero = no pool);
// write it only while no request is in flight.
// Throughput: one request per cycle while m_axis_tready is high or no response is
// held; the free-map register is read, searched and rewritten in the single step
// between the request register and the response register.
// Reset: base goes to zero, every block marked free, both stages empty.
// Stall: while m_axis_tready is low a held response keeps its data; one more
// request waits in the request register, after which s_axis_tready drops.
// Depends on bba_pkg, bba_step and bitmap_block_allocator_core_macros.svh.
`include "bitmap_block_allocator_core_macros.svh"
module bitmap_block_allocator_core #(
    parameter int unsigned NUM_BLOCKS  = 64,
    parameter int unsigned BLOCK_SHIFT = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bba_pkg::AddrW-1:0]     i_cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // release_address
    input  logic [0:0]                    s_axis_tuser,  // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], granted_index[7:2], granted_address[71:8], free_map_out[135:72]
    output logic [135:0]                  m_axis_tdata
);
    import bba_pkg::*;

    localparam logic [MapW-1:0] PoolMask = (NUM_BLOCKS >= 64) ? {MapW{1'b1}} :
                                           ((64'd1 << NUM_BLOCKS) - 64'd1);

    logic              r_in_valid;
    t_req              r_in;
    logic              r_out_valid;
    t_rsp              r_out;
    logic [MapW-1:0]   r_map;
    logic [AddrW-1:0]  r_base;
    t_rsp              n_out;
    logic              w_adv;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    bba_step #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_step (
        .i_req  (r_in),
        .i_base (r_base),
        .i_map  (r_map),
        .o_rsp  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.func    <= t_func'(s_axis_tuser[0]);
            r_in.address <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_map       <= '1;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_map <= n_out.map;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    `BBA_ASSERT(a_map_above_pool, i_clk, i_rst_n, (r_map | PoolMask) == {MapW{1'b1}}, "map bit above pool cleared")
    `BBA_ASSERT(a_fail_zero, i_clk, i_rst_n, !(r_out_valid && r_out.status != ST_OK) || (r_out.index == '0 && r_out.address == '0), "failed request returned a block")
    `BBA_ASSERT(a_nomem_empty, i_clk, i_rst_n, !(r_out_valid && r_out.status == ST_NOMEM) || r_base == '0 || (r_out.map & PoolMask) == '0, "out of memory with a free block")
    `BBA_ASSERT(a_grant_taken, i_clk, i_rst_n, !(r_out_valid && r_out.status == ST_OK && r_out.index != '0) || !r_out.map[r_out.index], "granted block still free")
    `BBA_ASSERT_NEXT(a_map_tracks, i_clk, i_rst_n, w_adv && r_in_valid, r_out_valid && r_map == r_out.map, "map and response disagree")

endmodule
